/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the block allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define BBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked in every cycle, reset included.
`define BBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Sizes, status codes and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int NUM_BLOCKS = 4096;
    localparam int WORD_W     = 64;
    localparam int WORD_AW    = $clog2(WORD_W);
    localparam int MAP_WORDS  = NUM_BLOCKS / WORD_W;
    localparam int MAP_AW     = $clog2(MAP_WORDS);
    localparam int WCNT_W     = $clog2(MAP_WORDS + 1);
    localparam int BLK_W      = 12;
    localparam int CNT_W      = 13;
    localparam int STS_W      = 2;

    localparam logic [CNT_W-1:0] CFG_COUNT_RESET = CNT_W'(4096);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_WAS_FREE = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic free_rd;
        logic free_chk;
        logic alloc_hit;
        logic alloc_full;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_free;
        logic in_range;
        logic hit;
        logic scan_end;
        logic out_free;
    } t_sts;

endpackage

/* hw/rtl/bba_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocate or free request.
// ----------------------------------------------------------------------------
interface bba_req_if import bba_pkg::*; ();

    logic             valid;
    logic             ready;
    logic             operation;
    logic [BLK_W-1:0] block_number;

    modport source (output valid, output operation, output block_number, input ready);
    modport sink   (input valid, input operation, input block_number, output ready);

endinterface

/* hw/rtl/bba_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one allocator result.
// ----------------------------------------------------------------------------
interface bba_rsp_if import bba_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [BLK_W-1:0] allocated_block;
    logic [STS_W-1:0] status;

    modport source (output valid, output allocated_block, output status, input ready);
    modport sink   (input valid, input allocated_block, input status, output ready);

endinterface

/* hw/rtl/bba_datapath.sv */
// ----------------------------------------------------------------------------
// Block bitmap allocator datapath
// Bitmap memory, word scanner, free check, result and output registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_datapath import bba_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data,
    input  logic             i_req_op,
    input  logic [BLK_W-1:0] i_req_blk,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output logic [BLK_W-1:0] o_rsp_block,
    output logic [STS_W-1:0] o_rsp_status
);

    // Index of the lowest set bit, found by halving the window six times.
    function automatic logic [WORD_AW-1:0] f_lowest_set(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0]  w;
        logic [WORD_AW-1:0] idx;
        w   = v;
        idx = '0;
        for (int s = WORD_AW - 1; s >= 0; s--) begin
            if ((w & ((WORD_W'(1) << (1 << s)) - WORD_W'(1))) == '0) begin
                idx[s] = 1'b1;
                w      = w >> (1 << s);
            end
        end
        return idx;
    endfunction

    logic [CNT_W-1:0]   r_cfg_count;
    logic [CNT_W-1:0]   w_limit;
    logic [WCNT_W-1:0]  w_full_words;
    logic [WORD_AW-1:0] w_tail;
    logic [WCNT_W-1:0]  w_n_words;

    logic [BLK_W-1:0]   r_blk;
    logic [WCNT_W-1:0]  r_issue;
    logic               r_pend;
    logic [MAP_AW-1:0]  r_chk_word;

    logic [WORD_W-1:0]  r_map [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_row_vld;
    logic [WORD_W-1:0]  r_rd_data;
    logic               r_rd_vld;

    logic               w_issue_ok;
    logic               w_in_range;
    logic               w_rd_en;
    logic [MAP_AW-1:0]  w_rd_addr;
    logic               w_wr_en;
    logic [WORD_W-1:0]  w_word;
    logic [WORD_W-1:0]  w_mask;
    logic [WORD_W-1:0]  w_free_bits;
    logic               w_hit;
    logic [WORD_AW-1:0] w_hit_idx;
    logic [WORD_AW-1:0] w_blk_bit;
    logic               w_bit_used;

    logic [BLK_W-1:0]   r_res_block;
    t_status            r_res_status;
    logic               r_wr_pend;
    logic [MAP_AW-1:0]  r_wr_addr;
    logic [WORD_W-1:0]  r_wr_data;

    logic               r_out_vld;
    logic [BLK_W-1:0]   r_out_block;
    t_status            r_out_status;

    // Block count register; values above the capacity saturate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= CFG_COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg_count <= i_cfg_wr_data;
        end
    end

    assign w_limit      = (r_cfg_count > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : r_cfg_count;
    assign w_full_words = WCNT_W'(w_limit >> WORD_AW);
    assign w_tail       = w_limit[WORD_AW-1:0];
    assign w_n_words    = w_full_words + WCNT_W'(w_tail != '0);

    assign w_issue_ok = r_issue < w_n_words;
    assign w_in_range = CNT_W'(r_blk) < w_limit;
    assign w_rd_en    = (i_cmd.scan && w_issue_ok) || (i_cmd.free_rd && w_in_range);
    assign w_rd_addr  = i_cmd.free_rd ? r_blk[BLK_W-1:WORD_AW] : r_issue[MAP_AW-1:0];
    assign w_wr_en    = i_cmd.commit && r_wr_pend;

    // Bitmap store; a row never written reads as all free.
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_map[w_rd_addr];
        end
        if (w_wr_en) begin
            r_map[r_wr_addr] <= r_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (w_rd_en) begin
                r_rd_vld <= r_row_vld[w_rd_addr];
            end
            if (w_wr_en) begin
                r_row_vld[r_wr_addr] <= 1'b1;
            end
        end
    end

    assign w_word = r_rd_vld ? r_rd_data : '0;

    // Only blocks below the active count take part in the scan.
    assign w_mask      = ({1'b0, r_chk_word} < w_full_words) ? '1
                         : ((WORD_W'(1) << w_tail) - WORD_W'(1));
    assign w_free_bits = ~w_word & w_mask;
    assign w_hit       = r_pend && (w_free_bits != '0);
    assign w_hit_idx   = f_lowest_set(w_free_bits);
    assign w_blk_bit   = r_blk[WORD_AW-1:0];
    assign w_bit_used  = w_word[w_blk_bit];

    // Request capture and scan pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= '0;
            r_pend  <= 1'b0;
        end else if (i_cmd.load) begin
            r_issue <= '0;
            r_pend  <= 1'b0;
        end else if (i_cmd.scan) begin
            r_pend <= w_issue_ok;
            if (w_issue_ok) begin
                r_issue <= r_issue + WCNT_W'(1);
            end
        end else begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_blk <= i_req_blk;
        end
        if (i_cmd.scan && w_issue_ok) begin
            r_chk_word <= r_issue[MAP_AW-1:0];
        end
    end

    // Result held until it can be committed to the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend <= 1'b0;
        end else if (i_cmd.alloc_hit) begin
            r_wr_pend <= 1'b1;
        end else if (i_cmd.free_chk) begin
            r_wr_pend <= w_bit_used;
        end else if (i_cmd.alloc_full || i_cmd.free_rd || i_cmd.commit) begin
            r_wr_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_hit) begin
            r_res_block  <= {r_chk_word, w_hit_idx};
            r_res_status <= ST_OK;
            r_wr_addr    <= r_chk_word;
            r_wr_data    <= w_word | (WORD_W'(1) << w_hit_idx);
        end else if (i_cmd.alloc_full) begin
            r_res_block  <= '0;
            r_res_status <= ST_FULL;
        end else if (i_cmd.free_rd && !w_in_range) begin
            r_res_block  <= '0;
            r_res_status <= ST_RANGE;
        end else if (i_cmd.free_chk) begin
            r_res_block  <= '0;
            r_res_status <= w_bit_used ? ST_OK : ST_WAS_FREE;
            r_wr_addr    <= r_blk[BLK_W-1:WORD_AW];
            r_wr_data    <= w_word & ~(WORD_W'(1) << w_blk_bit);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_block  <= r_res_block;
            r_out_status <= r_res_status;
        end
    end

    assign o_rsp_valid  = r_out_vld;
    assign o_rsp_block  = r_out_block;
    assign o_rsp_status = r_out_status;

    assign o_sts.in_free  = (i_req_op == OP_FREE);
    assign o_sts.in_range = w_in_range;
    assign o_sts.hit      = w_hit;
    assign o_sts.scan_end = !r_pend && !w_issue_ok;
    assign o_sts.out_free = !r_out_vld || i_rsp_ready;

    `BBA_ASSERT(a_no_rw_clash, i_clk, i_rst_n, !(w_rd_en && w_wr_en), "map read and write collide")
    `BBA_ASSERT(a_fail_block_zero, i_clk, i_rst_n, (r_out_vld && r_out_status != ST_OK) |-> (r_out_block == '0), "failed result carries a block number")
    `BBA_ASSERT(a_scan_in_limit, i_clk, i_rst_n, (i_cmd.scan && r_pend) |-> ({1'b0, r_chk_word} < w_n_words), "scan checks a word beyond the count")

endmodule

/* hw/rtl/bba_ctrl.sv */
// ----------------------------------------------------------------------------
// Block bitmap allocator controller
// Sequences one request at a time through the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_ctrl import bba_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SCAN     = 5'b00010,
        S_FREE_RD  = 5'b00100,
        S_FREE_CHK = 5'b01000,
        S_DONE     = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.in_free ? S_FREE_RD : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.alloc_hit = 1'b1;
                    n_state         = S_DONE;
                end else if (i_sts.scan_end) begin
                    o_cmd.alloc_full = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_FREE_RD: begin
                o_cmd.free_rd = 1'b1;
                n_state       = i_sts.in_range ? S_FREE_CHK : S_DONE;
            end
            S_FREE_CHK: begin
                o_cmd.free_chk = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);

    `BBA_ASSERT(a_done_exit, i_clk, i_rst_n, (r_state == S_DONE) |=> (r_state == S_DONE || r_state == S_IDLE), "result state left for a work state")
    `BBA_ASSERT(a_one_decision, i_clk, i_rst_n, $onehot0({o_cmd.alloc_hit, o_cmd.alloc_full, o_cmd.free_chk, o_cmd.commit}), "two results decided at once")

endmodule

/* hw/rtl/block_bitmap_allocator_core.sv */
// ----------------------------------------------------------------------------
// Block bitmap allocator core
// First-fit allocator over a used/free bitmap of 4096 blocks.
// ----------------------------------------------------------------------------
// The core serves one request at a time and gives exactly one result for each.
// An allocate takes the lowest free block below the configured block count,
// marks it used and returns its number; a free clears the bit of the given
// block. The bitmap lives in a 64-word by 64-bit memory that is scanned one
// word per cycle through its single read port, so an allocate finishes
// sooner when the first free block lies in an early word. Each memory row
// has a valid bit that reset clears, so the whole map reads as free
// straight after reset with no clearing pass. The result sits in an output
// register, so the next request is taken as soon as the previous result has
// been loaded there. The block count register may only be written while the
// core is idle; values above 4096 act as 4096, and a count of zero makes
// every allocate report out of blocks and every free report out of range.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_core import bba_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data,
    bba_req_if.sink          i_req,
    bba_rsp_if.source        o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;

    // The controller decides the order of work; it sees the request valid
    // and returns ready only while it waits for a new transfer.
    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the bitmap, the block count and the output register.
    bba_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_op      (i_req.operation),
        .i_req_blk     (i_req.block_number),
        .o_rsp_valid   (o_rsp.valid),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_block   (o_rsp.allocated_block),
        .o_rsp_status  (o_rsp.status)
    );

endmodule

/* tb/bba_allocation_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Allocation checker
// Follows the request, response and block count traffic of the allocator,
// works out the response owed to every request and compares it in order.
// ----------------------------------------------------------------------------
module bba_allocation_checker import bba_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data,
    bba_req_if               i_req,
    bba_rsp_if               i_rsp,
    output int               o_fail_count,
    output int               o_outstanding
);

    typedef struct packed {
        logic [BLK_W-1:0] block;
        t_status          status;
    } t_grant;

    bit   [NUM_BLOCKS-1:0] block_taken;
    logic [CNT_W-1:0]      block_count;
    t_grant                expected_grants[$];
    int                    failures = 0;

    assign o_fail_count = failures;

    // First-fit allocation or release against the shadow map.
    function automatic t_grant serve_request(input logic op, input logic [BLK_W-1:0] blk);
        t_grant res;
        int     limit;
        res.block = '0;
        limit     = (block_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(block_count);
        if (op == OP_ALLOC) begin
            res.status = ST_FULL;
            for (int i = 0; i < limit; i++) begin
                if (!block_taken[i]) begin
                    block_taken[i] = 1'b1;
                    res.block      = BLK_W'(i);
                    res.status     = ST_OK;
                    break;
                end
            end
        end else if (int'(blk) >= limit) begin
            res.status = ST_RANGE;
        end else if (!block_taken[blk]) begin
            res.status = ST_WAS_FREE;
        end else begin
            block_taken[blk] = 1'b0;
            res.status       = ST_OK;
        end
        return res;
    endfunction

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= 10) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    always @(posedge i_clk) begin : track
        t_grant want;
        if (!i_rst_n) begin
            block_taken = '0;
            block_count = CFG_COUNT_RESET;
            expected_grants.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_grants.size() == 0) begin
                    report_failure($sformatf("response block %0d status %0d with none expected",
                                             i_rsp.allocated_block, i_rsp.status));
                end else begin
                    want = expected_grants.pop_front();
                    if (i_rsp.allocated_block !== want.block || i_rsp.status !== want.status) begin
                        report_failure($sformatf("expected block %0d status %s, got block %0d status %0d",
                                                 want.block, want.status.name(),
                                                 i_rsp.allocated_block, i_rsp.status));
                    end
                end
            end
            if (i_cfg_wr_en) begin
                block_count = i_cfg_wr_data;
            end
            if (i_req.valid && i_req.ready) begin
                expected_grants.push_back(serve_request(i_req.operation, i_req.block_number));
            end
        end
        o_outstanding <= expected_grants.size();
    end

endmodule

/* tb/tb_block_bitmap_allocator_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block bitmap allocator core testbench
// Sends allocate and free requests under several block counts, with random
// gaps and stalls on both channels, and leaves checking to the checker.
// ----------------------------------------------------------------------------
module tb_block_bitmap_allocator_core;
    import bba_pkg::*;

    // Length of the long response hold-off, in clock cycles. It is well beyond
    // the time the core needs to take one request and park a second result,
    // so the request channel is certain to back up behind it.
    localparam int HOLD_CYCLES  = 300;
    // Settling time after the last result: a full-count scan plus margin.
    localparam int DRAIN_CYCLES = 80;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;
    int               fail_count;
    int               outstanding;

    // When calm is set neither side idles, giving back-to-back traffic.
    bit               calm         = 1'b0;
    // Set by the stimulus to ask the response side for a long hold-off.
    bit               hold_request = 1'b0;
    int               hold_left    = 0;

    bba_req_if req_if ();
    bba_rsp_if rsp_if ();

    block_bitmap_allocator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_if),
        .o_rsp         (rsp_if)
    );

    bba_allocation_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_if),
        .i_rsp         (rsp_if),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the core hangs; far beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Response side. Ready is dropped in roughly one cycle in ten, except
    // during calm stretches. A hold-off request from the stimulus is picked
    // up here and counted down cycle by cycle, with ready held low meanwhile.
    initial begin : response_sink
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= calm || ($urandom_range(99) >= 10);
            end
        end
    end

    // Offers one request and returns at the edge where it is transferred.
    // Valid is left high afterwards so that the next call can follow on
    // without a bubble; an idle gap, when chosen, lowers it first.
    task automatic offer_request(input logic op, input logic [BLK_W-1:0] blk);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 10) begin
            gap = $urandom_range(1, 6);
        end
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.operation    <= op;
        req_if.block_number <= blk;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // Stops offering and waits until every predicted result has been
    // transferred, which leaves the core idle.
    task automatic pause_for_results();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // The block count may only change while the core is idle.
    task automatic program_block_count(input logic [CNT_W-1:0] count);
        pause_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One random phase under a given block count. Most frees aim at the low
    // end of the map, where first-fit allocation keeps the used blocks, so
    // that they mostly release real allocations; the rest probe the top
    // boundary of the count or land anywhere in the block number field.
    task automatic run_phase(input logic [CNT_W-1:0] count, input int items,
                             input int alloc_pct, input int calm_items, input bit hold);
        int               eff;
        int               window;
        int               pick;
        logic [BLK_W-1:0] blk;
        program_block_count(count);
        eff    = (count > NUM_BLOCKS) ? NUM_BLOCKS : int'(count);
        window = (eff < 128) ? eff : 128;
        if (hold) begin
            hold_request = 1'b1;
        end
        for (int k = 0; k < items; k++) begin
            calm = (k < calm_items);
            if ($urandom_range(99) < alloc_pct) begin
                offer_request(OP_ALLOC, BLK_W'($urandom));
            end else begin
                pick = $urandom_range(99);
                if (pick < 75) begin
                    blk = BLK_W'($urandom_range(0, window - 1));
                end else if (pick < 85) begin
                    blk = BLK_W'(eff - 1 + $urandom_range(0, 1));
                end else begin
                    blk = BLK_W'($urandom);
                end
                offer_request(OP_FREE, blk);
            end
        end
        calm = 1'b0;
    endtask

    initial begin : stimulus
        req_if.valid        <= 1'b0;
        req_if.operation    <= OP_ALLOC;
        req_if.block_number <= '0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        i_rst_n             <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset count: first-fit order, a release, a
        // release of a block that is already free, and the top block number.
        offer_request(OP_ALLOC, '0);
        offer_request(OP_ALLOC, '0);
        offer_request(OP_ALLOC, '0);
        offer_request(OP_FREE,  BLK_W'(1));
        offer_request(OP_FREE,  BLK_W'(1));
        offer_request(OP_FREE,  '1);
        offer_request(OP_ALLOC, '0);
        offer_request(OP_ALLOC, '1);
        offer_request(OP_FREE,  '0);

        // A count of zero: nothing can be allocated and nothing is in range.
        program_block_count('0);
        offer_request(OP_ALLOC, '0);
        offer_request(OP_FREE,  '0);

        // The largest count the register holds saturates to the map size.
        program_block_count('1);
        offer_request(OP_FREE,  '1);
        offer_request(OP_ALLOC, '0);

        // Shrinking below blocks already in use: the scan stops at the new
        // count, blocks above it cannot be freed, blocks below still can.
        program_block_count(CNT_W'(3));
        offer_request(OP_ALLOC, '0);
        offer_request(OP_FREE,  BLK_W'(3));
        offer_request(OP_FREE,  BLK_W'(2));
        offer_request(OP_ALLOC, '0);
        offer_request(OP_FREE,  '1);

        // Smallest non-zero count.
        program_block_count(CNT_W'(1));
        offer_request(OP_ALLOC, '0);
        offer_request(OP_FREE,  '0);
        offer_request(OP_ALLOC, '0);

        // Raising the count again exposes the bit kept above the old limit.
        program_block_count(CFG_COUNT_RESET);
        offer_request(OP_FREE,  BLK_W'(3));
        offer_request(OP_ALLOC, '0);
        offer_request(OP_ALLOC, '0);

        // Random part. Small counts fill up and hit word boundaries; the
        // full count starts under a long response hold-off so the core backs
        // up; one phase runs a long stretch with no idling on either side.
        run_phase(CNT_W'(8),    90,  55, 0,  1'b0);
        run_phase(CNT_W'(64),   90,  60, 0,  1'b0);
        run_phase(CNT_W'(65),   90,  60, 0,  1'b0);
        run_phase(CNT_W'(200),  120, 65, 60, 1'b0);
        run_phase(CFG_COUNT_RESET, 120, 60, 0, 1'b1);
        run_phase(CNT_W'(1),    40,  50, 0,  1'b0);
        run_phase('1,           100, 60, 0,  1'b0);
        run_phase(CNT_W'($urandom_range(2, 4095)), 100, 60, 0, 1'b0);

        pause_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
